// ----- design/lci_pkg.sv -----
// Shared types, widths and codes of the line and circle intersection block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
package lci_pkg;

   // Coordinate width, signed Q12.4 at 16 bits
   localparam int CW   = 16;
   // Differences of two coordinates
   localparam int DW   = CW + 1;
   // A = |d|^2 (unsigned), H = d.e and C (signed)
   localparam int AW   = 2 * CW + 2;
   localparam int HW   = 2 * CW + 2;
   // Quarter discriminant, signed, even width for the square root
   localparam int QW   = 4 * CW + 4;
   // Square root and its remainder
   localparam int RW   = 2 * CW + 2;
   localparam int REMW = RW + 2;
   // Numerator -H +/- root, signed
   localparam int NW   = 2 * CW + 4;
   // Product d * numerator: signed width and magnitude width
   localparam int PRW  = DW + NW;
   localparam int PW   = 3 * CW + 3;
   // Quotient bits kept before saturation takes over
   localparam int QTW  = CW + 2;
   localparam int CMPW = AW + QTW;
   // Queue between the front and the back
   localparam int FIFO_DEPTH = 4;

   // Register indexes
   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_RADIUS   = 2'd2;

   // Hit counts
   localparam logic [1:0] HIT_NONE = 2'd0;
   localparam logic [1:0] HIT_ONE  = 2'd1;
   localparam logic [1:0] HIT_TWO  = 2'd2;

   typedef struct packed {
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [1:0]           hit_count;
      logic signed [CW-1:0] first_x;
      logic signed [CW-1:0] first_y;
      logic signed [CW-1:0] second_x;
      logic signed [CW-1:0] second_y;
   } rsp_type;

   typedef struct packed {
      logic signed [CW-1:0] center_x;
      logic signed [CW-1:0] center_y;
      logic [CW-2:0]        radius;
   } cfg_type;

   // Classified item handed from the front to the back
   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic signed [HW-1:0] h;
      logic [AW-1:0]        a;
      logic [QW-1:0]        q;
      logic [1:0]           cnt;
   } cls_type;

endpackage

// ----- design/line_circle_intersection.sv -----
// Line and circle intersection, top level: circle registers, front, queue and back.
// Depends on lci_pkg, lci_front, lci_fifo and lci_back.
`timescale 1ns / 1ps
// The block takes one line (two Q12.4 points) per cycle while neither side stalls
// and returns, for each, the number of crossings with the configured circle and
// up to two crossing points, saturated to Q12.4. An item passes a five-stage
// front and the registered queue, then the square root (one root bit per stage,
// 34 stages) and the four dividers (one quotient bit per stage, 18 stages).
// Both sides stall independently: the front writes into a four-entry queue
// and the back drains it into the result register. Circle registers are
// written through the csr port, which is always ready; an index above the
// radius is ignored.
module line_circle_intersection (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lci_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lci_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [lci_pkg::CW-1:0] csr_data
);
   import lci_pkg::*;

   cfg_type cfg_ff;
   logic    full, push, nonempty, pop;
   cls_type push_data, pop_data;

   assign csr_ready = 1'b1;

   // Hold circle registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X: cfg_ff.center_x <= csr_data;
            CSR_CENTER_Y: cfg_ff.center_y <= csr_data;
            CSR_RADIUS:   cfg_ff.radius   <= csr_data[CW-2:0];
            default:      ;
         endcase
      end
   end

   lci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .full      (full),
      .push      (push),
      .push_data (push_data)
   );

   lci_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .nonempty  (nonempty),
      .pop_data  (pop_data)
   );

   lci_back u_back (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (nonempty),
      .deq_ready (pop),
      .deq_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("transfer into full queue");

   // No hit leaves every point blank
   a_none_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_count == HIT_NONE |->
         rsp_data.first_x == '0 && rsp_data.first_y == '0 &&
         rsp_data.second_x == '0 && rsp_data.second_y == '0)
      else $error("points set with no hit");

   // A tangent leaves the second point blank
   a_one_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_count == HIT_ONE |->
         rsp_data.second_x == '0 && rsp_data.second_y == '0)
      else $error("second point set on tangent");

   // Classified counts stay within the defined codes
   a_count_code: assert property (@(posedge clock) disable iff (reset)
      push |-> push_data.cnt == HIT_NONE || push_data.cnt == HIT_ONE ||
               push_data.cnt == HIT_TWO)
      else $error("bad hit count");

endmodule

// ----- design/lci_front.sv -----
// Front of the block: forms A, H, C and the quarter discriminant, sets the hit count.
// Depends on lci_pkg.
`timescale 1ns / 1ps
module lci_front (
   input  logic              clock,
   input  logic              reset,
   input  lci_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  lci_pkg::req_type  req_data,
   input  logic              full,
   output logic              push,
   output lci_pkg::cls_type  push_data
);
   import lci_pkg::*;

   logic                 en;
   logic [4:0]           v_ff;
   cls_type              c0_ff, c1_ff, c2_ff, c3_ff, c4_ff;
   cls_type              c0_in, c2_in, c4_in;
   logic signed [DW-1:0] gx0_ff, gy0_ff;
   logic signed [2*DW-1:0] dxx1_ff, dyy1_ff, dxg1_ff, dyg1_ff, gxx1_ff, gyy1_ff;
   logic [2*CW-3:0]      rr1_ff;
   logic signed [HW-1:0] c2c_ff;
   logic signed [QW-1:0] hh3_ff, ac3_ff;
   logic signed [QW-1:0] q4;

   // Whole front holds while the queue is full
   assign en        = !full;
   assign req_ready = en;
   assign push      = v_ff[4] && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], req_valid};
      end
   end

   // Next stage words: differences, then A and H, then the discriminant
   always_comb begin
      c0_in    = '0;
      c0_in.sx = req_data.start_x;
      c0_in.sy = req_data.start_y;
      c0_in.dx = DW'(req_data.end_x) - DW'(req_data.start_x);
      c0_in.dy = DW'(req_data.end_y) - DW'(req_data.start_y);

      c2_in    = c1_ff;
      c2_in.a  = AW'(dxx1_ff + dyy1_ff);
      c2_in.h  = dxg1_ff + dyg1_ff;

      c4_in    = c3_ff;
      c4_in.q  = hh3_ff - ac3_ff;
   end

   // Differences, products, sums, squares, discriminant
   always_ff @(posedge clock) begin
      if (en) begin
         c0_ff  <= c0_in;
         gx0_ff <= DW'(req_data.start_x) - DW'(cfg.center_x);
         gy0_ff <= DW'(req_data.start_y) - DW'(cfg.center_y);

         c1_ff   <= c0_ff;
         dxx1_ff <= c0_ff.dx * c0_ff.dx;
         dyy1_ff <= c0_ff.dy * c0_ff.dy;
         dxg1_ff <= c0_ff.dx * gx0_ff;
         dyg1_ff <= c0_ff.dy * gy0_ff;
         gxx1_ff <= gx0_ff * gx0_ff;
         gyy1_ff <= gy0_ff * gy0_ff;
         rr1_ff  <= cfg.radius * cfg.radius;

         c2_ff  <= c2_in;
         c2c_ff <= gxx1_ff + gyy1_ff - $signed(HW'(rr1_ff));

         c3_ff  <= c2_ff;
         hh3_ff <= c2_ff.h * c2_ff.h;
         ac3_ff <= $signed({1'b0, c2_ff.a}) * c2c_ff;

         c4_ff <= c4_in;
      end
   end

   // Classify: degenerate line or negative discriminant gives no hit
   assign q4 = $signed(c4_ff.q);
   always_comb begin
      push_data = c4_ff;
      if (c4_ff.a == '0 || q4 < 0) begin
         push_data.cnt = HIT_NONE;
      end else if (q4 == 0) begin
         push_data.cnt = HIT_ONE;
      end else begin
         push_data.cnt = HIT_TWO;
      end
   end

endmodule

// ----- design/lci_fifo.sv -----
// Short queue of classified items between the front and the back.
// Depends on lci_pkg.
`timescale 1ns / 1ps
module lci_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lci_pkg::cls_type  push_data,
   output logic              full,
   input  logic              pop,
   output logic              nonempty,
   output lci_pkg::cls_type  pop_data
);
   import lci_pkg::*;

   localparam int PTRW = $clog2(FIFO_DEPTH);

   cls_type         mem_ff [FIFO_DEPTH];
   logic [PTRW-1:0] wr_ff, rd_ff;
   logic [PTRW:0]   cnt_ff;
   logic            do_pop;

   assign full     = cnt_ff == (PTRW+1)'(FIFO_DEPTH);
   assign nonempty = cnt_ff != '0;
   assign do_pop   = pop && nonempty;
   assign pop_data = mem_ff[rd_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (!push && do_pop) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ----- design/lci_back.sv -----
// Back of the block: pipelined square root, numerators, products, four dividers,
// rounding and saturation into the result register. Depends on lci_pkg.
`timescale 1ns / 1ps
module lci_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              deq_valid,
   output logic              deq_ready,
   input  lci_pkg::cls_type  deq_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lci_pkg::rsp_type  rsp_data
);
   import lci_pkg::*;

   logic en;

   // Square root stages
   logic            sq_v_ff    [RW+1];
   cls_type         sq_dat_ff  [RW+1];
   logic [REMW-1:0] sq_rem_ff  [RW+1];
   logic [RW-1:0]   sq_root_ff [RW+1];
   logic [QW-1:0]   sq_x_ff    [RW+1];

   // Numerator and product stages
   logic                  n_v_ff, m_v_ff;
   cls_type               n_dat_ff, m_dat_ff;
   logic signed [NW-1:0]  n_num1_ff, n_num2_ff;
   logic signed [PRW-1:0] m_p_ff [4];
   logic [RW:0]           rootr;

   // Divider stages, four lanes
   logic            dv_v_ff   [QTW+1];
   cls_type         dv_dat_ff [QTW+1];
   logic [PW-1:0]   dv_mag_ff [QTW+1][4];
   logic [QTW-1:0]  dv_quo_ff [QTW+1][4];
   logic            dv_neg_ff [QTW+1][4];
   logic            dv_ovf_ff [QTW+1][4];

   logic [CW-1:0]   pt [4];
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   // Round, restore sign, add the start point and saturate
   function automatic logic [CW-1:0] finish(input logic signed [CW-1:0] s,
                                            input logic [PW-1:0] rem,
                                            input logic [QTW-1:0] quo,
                                            input logic neg, input logic ovf,
                                            input logic [AW-1:0] a);
      logic                    rnd;
      logic [QTW:0]            rq;
      logic signed [QTW+2:0]   off, sum;
      logic signed [QTW+2:0]   lo, hi;
      rnd = {AW'(rem), 1'b0} >= {1'b0, a};
      rq  = (QTW+1)'(quo) + (QTW+1)'(rnd);
      off = neg ? -$signed((QTW+3)'(rq)) : $signed((QTW+3)'(rq));
      sum = (QTW+3)'(s) + off;
      hi  = (QTW+3)'($signed({1'b0, {(CW-1){1'b1}}}));
      lo  = (QTW+3)'($signed({1'b1, {(CW-1){1'b0}}}));
      if (ovf) return neg ? CW'(lo) : CW'(hi);
      if (sum > hi) return CW'(hi);
      if (sum < lo) return CW'(lo);
      return CW'(sum);
   endfunction

   assign en        = !rsp_valid_ff || rsp_ready;
   assign deq_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Take an item from the queue into the first root stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         sq_v_ff[0] <= deq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_dat_ff[0]  <= deq_data;
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_x_ff[0]    <= deq_data.q;
      end
   end

   // One root bit per stage
   for (genvar j = 1; j <= RW; j++) begin : g_sqrt
      logic [REMW+1:0] rs, tr;
      logic            ge;

      assign rs = {sq_rem_ff[j-1], sq_x_ff[j-1][QW-1 -: 2]};
      assign tr = {2'b00, sq_root_ff[j-1], 2'b01};
      assign ge = rs >= tr;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[j] <= 1'b0;
         end else if (en) begin
            sq_v_ff[j] <= sq_v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_dat_ff[j]  <= sq_dat_ff[j-1];
            sq_rem_ff[j]  <= ge ? REMW'(rs - tr) : rs[REMW-1:0];
            sq_root_ff[j] <= {sq_root_ff[j-1][RW-2:0], ge};
            sq_x_ff[j]    <= {sq_x_ff[j-1][QW-3:0], 2'b00};
         end
      end
   end

   // Round the root to nearest and form both numerators
   assign rootr = (RW+1)'(sq_root_ff[RW])
                + (RW+1)'(sq_rem_ff[RW] > REMW'(sq_root_ff[RW]));

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= 1'b0;
         m_v_ff <= 1'b0;
      end else if (en) begin
         n_v_ff <= sq_v_ff[RW];
         m_v_ff <= n_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_dat_ff  <= sq_dat_ff[RW];
         n_num1_ff <= $signed(NW'(rootr)) - NW'(sq_dat_ff[RW].h);
         n_num2_ff <= -NW'(sq_dat_ff[RW].h) - $signed(NW'(rootr));
         m_dat_ff  <= n_dat_ff;
         m_p_ff[0] <= n_dat_ff.dx * n_num1_ff;
         m_p_ff[1] <= n_dat_ff.dy * n_num1_ff;
         m_p_ff[2] <= n_dat_ff.dx * n_num2_ff;
         m_p_ff[3] <= n_dat_ff.dy * n_num2_ff;
      end
   end

   // Divider entry: magnitude, sign and overflow against A shifted up
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (en) begin
         dv_v_ff[0] <= m_v_ff;
      end
   end

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [PW-1:0] mag;

      assign mag = PW'(m_p_ff[l][PRW-1] ? -m_p_ff[l] : m_p_ff[l]);

      always_ff @(posedge clock) begin
         if (en) begin
            dv_mag_ff[0][l] <= mag;
            dv_quo_ff[0][l] <= '0;
            dv_neg_ff[0][l] <= m_p_ff[l][PRW-1];
            dv_ovf_ff[0][l] <= CMPW'(mag) >= (CMPW'(m_dat_ff.a) << QTW);
         end
      end

      // One quotient bit per stage
      for (genvar j = 1; j <= QTW; j++) begin : g_div
         logic [CMPW-1:0] sub;
         logic            ge;

         assign sub = CMPW'(dv_dat_ff[j-1].a) << (QTW - j);
         assign ge  = CMPW'(dv_mag_ff[j-1][l]) >= sub;

         always_ff @(posedge clock) begin
            if (en) begin
               dv_mag_ff[j][l] <= ge ? PW'(CMPW'(dv_mag_ff[j-1][l]) - sub)
                                     : dv_mag_ff[j-1][l];
               dv_quo_ff[j][l] <= {dv_quo_ff[j-1][l][QTW-2:0], ge};
               dv_neg_ff[j][l] <= dv_neg_ff[j-1][l];
               dv_ovf_ff[j][l] <= dv_ovf_ff[j-1][l];
            end
         end
      end

      assign pt[l] = finish((l % 2 == 0) ? dv_dat_ff[QTW].sx : dv_dat_ff[QTW].sy,
                            dv_mag_ff[QTW][l], dv_quo_ff[QTW][l],
                            dv_neg_ff[QTW][l], dv_ovf_ff[QTW][l], dv_dat_ff[QTW].a);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_dat_ff[0] <= m_dat_ff;
      end
   end

   for (genvar j = 1; j <= QTW; j++) begin : g_divctl
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (en) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_dat_ff[j] <= dv_dat_ff[j-1];
         end
      end
   end

   // Result register: blank the points that the count does not cover
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_v_ff[QTW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.hit_count <= dv_dat_ff[QTW].cnt;
         rsp_data_ff.first_x   <= (dv_dat_ff[QTW].cnt != HIT_NONE) ? pt[0] : '0;
         rsp_data_ff.first_y   <= (dv_dat_ff[QTW].cnt != HIT_NONE) ? pt[1] : '0;
         rsp_data_ff.second_x  <= (dv_dat_ff[QTW].cnt == HIT_TWO) ? pt[2] : '0;
         rsp_data_ff.second_y  <= (dv_dat_ff[QTW].cnt == HIT_TWO) ? pt[3] : '0;
      end
   end

endmodule

// ----- tb/line_circle_intersection_tb.sv -----
// Testbench for line_circle_intersection: directed and random lines against a range of circles.
// Depends on lci_pkg and the block; results are checked against a wide-integer predictor.
`timescale 1ns / 1ps
module line_circle_intersection_tb;
   import lci_pkg::*;

   typedef logic signed [127:0] wide_t;

   // Register index that the block does not decode
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0]    csr_index;
   logic [CW-1:0] csr_data;

   // Circle as the block should hold it
   logic signed [CW-1:0] circ_cx;
   logic signed [CW-1:0] circ_cy;
   logic [CW-2:0]        circ_r;

   rsp_type expected_hits[$];
   int      errors;
   int      lines_sent;
   int      hits_seen[3];
   int      circles_used;
   bit      quiet;
   int      rsp_stall;

   line_circle_intersection u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Nearest integer square root of a non-negative value
   function automatic wide_t round_sqrt(wide_t n);
      wide_t res;
      wide_t t;
      res = 0;
      for (int b = 63; b >= 0; b--) begin
         t = res | (wide_t'(1) << b);
         if (t * t <= n) res = t;
      end
      if (n - res * res > res) res = res + 1;
      return res;
   endfunction

   // Start point plus d * num / a, rounded half away from zero, saturated
   function automatic logic signed [CW-1:0] crossing_coord(wide_t s, wide_t d, wide_t num,
                                                          wide_t a);
      wide_t p;
      wide_t mag;
      wide_t qt;
      wide_t rm;
      wide_t v;
      p   = d * num;
      mag = (p < 0) ? -p : p;
      qt  = mag / a;
      rm  = mag % a;
      if (2 * rm >= a) qt = qt + 1;
      v = s + ((p < 0) ? -qt : qt);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[CW-1:0];
   endfunction

   function automatic rsp_type predict_crossings(req_type it);
      wide_t sx, sy, dx, dy, gx, gy, rr, a, h, c, q, root;
      rsp_type res;
      sx = $signed(it.start_x);
      sy = $signed(it.start_y);
      dx = wide_t'($signed(it.end_x)) - sx;
      dy = wide_t'($signed(it.end_y)) - sy;
      gx = sx - wide_t'(circ_cx);
      gy = sy - wide_t'(circ_cy);
      rr = wide_t'({1'b0, circ_r});
      a  = dx * dx + dy * dy;
      h  = dx * gx + dy * gy;
      c  = gx * gx + gy * gy - rr * rr;
      q  = h * h - a * c;
      res = '0;
      if (a == 0 || q < 0) begin
         res.hit_count = HIT_NONE;
      end else if (q == 0) begin
         res.hit_count = HIT_ONE;
         res.first_x = crossing_coord(sx, dx, -h, a);
         res.first_y = crossing_coord(sy, dy, -h, a);
      end else begin
         root = round_sqrt(q);
         res.hit_count = HIT_TWO;
         res.first_x  = crossing_coord(sx, dx, -h + root, a);
         res.first_y  = crossing_coord(sy, dy, -h + root, a);
         res.second_x = crossing_coord(sx, dx, -h - root, a);
         res.second_y = crossing_coord(sy, dy, -h - root, a);
      end
      return res;
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(int v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[CW-1:0];
   endfunction

   // Send one line; hold valid until the transfer, then predict
   task automatic send_line(req_type it);
      int gap;
      @(negedge clock);
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      expected_hits.push_back(predict_crossings(it));
      lines_sent++;
   endtask

   task automatic end_lines();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Wait for every result, then let the pipeline empty
   task automatic drain();
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [CW-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CENTER_X: circ_cx = val;
         CSR_CENTER_Y: circ_cy = val;
         CSR_RADIUS:   circ_r  = val[CW-2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_circle(int cx, int cy, int r);
      csr_write(CSR_CENTER_X, cx[CW-1:0]);
      csr_write(CSR_CENTER_Y, cy[CW-1:0]);
      csr_write(CSR_RADIUS, r[CW-1:0]);
      // unknown index: must leave the circle alone
      csr_write(CSR_UNUSED, CW'($urandom));
      circles_used++;
   endtask

   function automatic req_type make_line(int sx, int sy, int ex, int ey);
      req_type it;
      it.start_x = clamp_coord(sx);
      it.start_y = clamp_coord(sy);
      it.end_x   = clamp_coord(ex);
      it.end_y   = clamp_coord(ey);
      return it;
   endfunction

   // Mostly lines through the neighbourhood of the circle, some fully random
   function automatic req_type random_line();
      req_type it;
      int span;
      if ($urandom_range(0, 3) == 0) begin
         it = req_type'({$urandom, $urandom});
      end else begin
         span = 2 * int'(circ_r) + 64;
         it = make_line(int'(circ_cx) + $urandom_range(0, 2 * span) - span,
                        int'(circ_cy) + $urandom_range(0, 2 * span) - span,
                        int'(circ_cx) + $urandom_range(0, 2 * span) - span,
                        int'(circ_cy) + $urandom_range(0, 2 * span) - span);
         // occasionally a degenerate line
         if ($urandom_range(0, 19) == 0) begin
            it.end_x = it.start_x;
            it.end_y = it.start_y;
         end
      end
      return it;
   endfunction

   task automatic test_directed();
      set_circle(0, 0, 160);
      send_line(make_line(32, 48, 32, 48));            // equal points
      send_line(make_line(-800, 400, 800, 400));       // misses
      send_line(make_line(-320, 160, 320, 160));       // tangent from above
      send_line(make_line(160, -500, 160, 500));       // vertical tangent
      send_line(make_line(-320, 0, 320, 0));           // through the centre
      send_line(make_line(0, 0, 1, 1));                // short line from the centre
      send_line(make_line(-32768, -32768, 32767, 32767));
      send_line(make_line(32767, -32768, -32768, 32767));
      send_line(make_line(-32768, 0, 32767, 0));
      send_line(make_line(-32768, -32768, -32768, -32768));
      end_lines();
      drain();
      // extreme circles: big radius at the corners, zero radius
      set_circle(32767, -32768, 32767);
      send_line(make_line(0, 0, 16, 0));
      send_line(make_line(-32768, -32768, 32767, 32767));
      send_line(make_line(32767, 32767, 32767, -32768));
      send_line(make_line(1, 1, 0, 0));
      end_lines();
      drain();
      set_circle(-32768, 32767, 0);
      send_line(make_line(-32768, 0, -32768, 32767));  // passes through a point circle
      send_line(make_line(-32768, 32767, 0, 0));
      send_line(make_line(0, 0, 100, 3));
      end_lines();
      drain();
   endtask

   task automatic test_random_circles(int phases, int per_phase);
      for (int p = 0; p < phases; p++) begin
         case ($urandom_range(0, 3))
            0: set_circle($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                          $urandom_range(0, 32767));
            1: set_circle($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                          $urandom_range(0, 32767));
            default: set_circle($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                                $urandom_range(1, 800));
         endcase
         for (int i = 0; i < per_phase; i++) send_line(random_line());
         end_lines();
         drain();
      end
   endtask

   // Receiver: random stall bursts, none once quiet
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready <= 1'b1;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 10);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            exp_r = expected_hits.pop_front();
            if (exp_r.hit_count <= HIT_TWO) hits_seen[exp_r.hit_count]++;
            if (rsp_data.hit_count !== exp_r.hit_count ||
                rsp_data.first_x !== exp_r.first_x || rsp_data.first_y !== exp_r.first_y ||
                rsp_data.second_x !== exp_r.second_x ||
                rsp_data.second_y !== exp_r.second_y) begin
               $display("%0t: mismatch expected cnt=%0d p1=(%0d,%0d) p2=(%0d,%0d)",
                        $time, exp_r.hit_count, exp_r.first_x, exp_r.first_y,
                        exp_r.second_x, exp_r.second_y);
               $display("%0t: mismatch actual   cnt=%0d p1=(%0d,%0d) p2=(%0d,%0d)",
                        $time, rsp_data.hit_count, rsp_data.first_x, rsp_data.first_y,
                        rsp_data.second_x, rsp_data.second_y);
               errors++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      circ_cx = '0;
      circ_cy = '0;
      circ_r = '0;
      errors = 0;
      lines_sent = 0;
      circles_used = 0;
      quiet = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset circle first: radius zero at the origin
      send_line(make_line(-16, 0, 16, 0));
      send_line(make_line(5, 7, -9, 3));
      end_lines();
      drain();

      test_directed();
      test_random_circles(6, 120);
      quiet = 1'b1;
      test_random_circles(1, 80);

      if (expected_hits.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_hits.size());
         errors++;
      end
      $display("Sent %0d lines over %0d circles", lines_sent, circles_used);
      $display("Results with 0/1/2 crossings: %0d/%0d/%0d, errors %0d",
               hits_seen[0], hits_seen[1], hits_seen[2], errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
